// File: hdl/mwe_pkg.sv
package mwe_pkg;

  localparam int RateW     = 32;
  localparam int DevW      = 32;
  localparam int CodeW     = 8;
  localparam int ClkW      = 26;
  localparam int ExpW      = 4;
  localparam int RateManW  = 16;
  localparam int DevManW   = 8;
  localparam int CntW      = 6;
  localparam int InW       = 72;
  localparam int OutW      = 40;

  // Last exponent tried by the search and last step of the dividers.
  localparam logic [CntW-1:0] SearchLast = 6'd11;
  localparam logic [CntW-1:0] DivLast    = 6'd63;

  // Configuration register indexes.
  localparam logic CfgCrystal   = 1'b0;
  localparam logic CfgThreshold = 1'b1;

  localparam logic [ClkW-1:0] CrystalReset   = 26'd50000000;
  localparam logic [ClkW-1:0] ThresholdReset = 26'd30000000;

  typedef struct packed {
    logic load;
    logic search;
    logic div_init;
    logic div_step;
    logic mult;
    logic diff;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_status_t;

endpackage

// File: hdl/modulation_word_encoder.sv
// From an accepted input item to m_tvalid the controller steps through the exponent
// search, a setup step, 64 restoring-division steps, multiply, subtract and round.
// One item is in flight at a time: the next is accepted once the controller is idle.
// A new item is accepted while a finished result still waits in the output register.
// Reset (rst, synchronous): controller idle, output empty, crystal 50 MHz, threshold 30 MHz.
module modulation_word_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // rate_bps [31:0], deviation_hz [63:32], modulation_code [71:64]
  input  logic [mwe_pkg::InW-1:0]        s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // rate_mantissa [15:0], rate_exponent [19:16], dev_mantissa [27:20],
  // dev_exponent [31:28], mod2_byte [39:32]
  output logic [mwe_pkg::OutW-1:0]       m_tdata,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [mwe_pkg::ClkW-1:0]       cfg_data
);
  import mwe_pkg::*;

  logic [ClkW-1:0] crystal_hz;
  logic [ClkW-1:0] threshold_hz;
  ctrl_cmd_t       cmd;
  ctrl_status_t    status;

  // Configuration registers. Writes are expected only while the block is idle,
  // so the datapath samples them once when an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      crystal_hz   <= CrystalReset;
      threshold_hz <= ThresholdReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgCrystal:   crystal_hz   <= cfg_data;
        CfgThreshold: threshold_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  // The controller sequences search, division and rounding; the datapath
  // holds the operands, the two divider lanes and the output register.
  mwe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mwe_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_data      (s_tdata),
    .crystal_hz   (crystal_hz),
    .threshold_hz (threshold_hz),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata)
  );

  // Only one item is in flight: after an accept the input side closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // The MOD2 byte always carries the rate exponent bits.
  a_mod2_has_exp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[35:32] & m_tdata[19:16]) == m_tdata[19:16]))
    else $error("mod2 byte lost rate exponent bits");

  // Exponents never exceed twelve.
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[19:16] <= 4'd12 && m_tdata[31:28] <= 4'd12))
    else $error("exponent out of range");

endmodule

// File: hdl/mwe_ctrl.sv
module mwe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mwe_pkg::ctrl_status_t status,
  output mwe_pkg::ctrl_cmd_t    cmd
);
  import mwe_pkg::*;

  typedef enum logic [2:0] {
    IDLE, SEARCH, INIT, DIVIDE, MULT, DIFF, FINISH
  } state_t;

  state_t          state;
  logic [CntW-1:0] cnt;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == IDLE) && in_valid;
    cmd.search   = (state == SEARCH);
    cmd.div_init = (state == INIT);
    cmd.div_step = (state == DIVIDE);
    cmd.mult     = (state == MULT);
    cmd.diff     = (state == DIFF);
    cmd.finish   = (state == FINISH) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          cnt <= '0;
          if (in_valid) state <= SEARCH;
        end
        SEARCH: begin
          if (cnt == SearchLast) begin
            state <= INIT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        INIT: begin
          state <= DIVIDE;
          cnt   <= '0;
        end
        DIVIDE: begin
          if (cnt == DivLast) state <= MULT;
          cnt <= cnt + 1'b1;
        end
        MULT:   state <= DIFF;
        DIFF:   state <= FINISH;
        FINISH: begin
          if (status.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: hdl/mwe_datapath.sv
module mwe_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mwe_pkg::ctrl_cmd_t            cmd,
  output mwe_pkg::ctrl_status_t         status,
  input  logic [mwe_pkg::InW-1:0]       in_data,
  input  logic [mwe_pkg::ClkW-1:0]      crystal_hz,
  input  logic [mwe_pkg::ClkW-1:0]      threshold_hz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mwe_pkg::OutW-1:0]      out_data
);
  import mwe_pkg::*;

  function automatic logic [31:0] rate_lim(input logic [ClkW-1:0] f, input logic [ExpW-1:0] e);
    logic [41:0] p0;
    logic [42:0] p1;
    logic [5:0]  sh;
    p0 = ({16'b0, f} << 16) - {16'b0, f};
    p1 = ({17'b0, f} << 17) - {17'b0, f};
    sh = 6'd33 - {2'b0, e};
    if (e == '0) rate_lim = 32'(p0 >> 32);
    else rate_lim = 32'(p1 >> sh);
  endfunction

  function automatic logic [31:0] dev_lim(input logic [ClkW-1:0] f, input logic [ExpW-1:0] e);
    logic [33:0] p0;
    logic [34:0] p1;
    logic [4:0]  sh;
    p0 = ({8'b0, f} << 8) - {8'b0, f};
    p1 = ({9'b0, f} << 9) - {9'b0, f};
    sh = 5'd23 - {1'b0, e};
    if (e == '0) dev_lim = 32'(p0 >> 22);
    else dev_lim = 32'(p1 >> sh);
  endfunction

  logic [RateW-1:0] rate;
  logic [DevW-1:0]  dev;
  logic [CodeW-1:0] code;
  logic [ClkW-1:0]  fdig, fxo;
  logic [ExpW-1:0]  re, de;
  logic             rfound, dfound;
  logic [63:0]      rtgt, dtgt, rdq, ddq, rdh, rdl, ddh, ddl;
  logic [ClkW-1:0]  rrem, drem;
  logic [42:0]      rlo;
  logic [34:0]      dlo;
  logic [5:0]       rsh, dsh;
  logic [63:0]      rtgt_next, dtgt_next;
  logic [ClkW:0]    rtry, dtry;
  logic             rge, dge;
  logic [RateManW-1:0] rman;
  logic [DevManW-1:0]  dman;

  assign status.out_free = !out_valid || out_ready;

  assign rsh = (re == '0) ? 6'd32 : 6'd33 - {2'b0, re};
  assign dsh = (de == '0) ? 6'd22 : 6'd23 - {2'b0, de};
  assign rtgt_next = {32'b0, rate} << rsh;
  assign dtgt_next = {32'b0, dev} << dsh;

  // One restoring-division step per lane: shift in the next dividend bit.
  assign rtry = {rrem, rdq[63]};
  assign dtry = {drem, ddq[63]};
  assign rge  = rtry >= {1'b0, fdig};
  assign dge  = dtry >= {1'b0, fxo};

  assign rman = rdq[RateManW-1:0] + RateManW'(rdh < rdl);
  assign dman = ddq[DevManW-1:0] + DevManW'(ddh < ddl);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate   <= in_data[31:0];
      dev    <= in_data[63:32];
      code   <= in_data[71:64];
      fxo    <= crystal_hz;
      fdig   <= (crystal_hz > threshold_hz) ? (crystal_hz >> 1) : crystal_hz;
      re     <= '0;
      de     <= '0;
      rfound <= 1'b0;
      dfound <= 1'b0;
    end
    if (cmd.search) begin
      if (!rfound) begin
        if (rate <= rate_lim(fdig, re)) rfound <= 1'b1;
        else re <= re + 1'b1;
      end
      if (!dfound) begin
        if (dev < dev_lim(fxo, de)) dfound <= 1'b1;
        else de <= de + 1'b1;
      end
    end
    if (cmd.div_init) begin
      rtgt <= rtgt_next;
      dtgt <= dtgt_next;
      rdq  <= rtgt_next;
      ddq  <= dtgt_next;
      rrem <= '0;
      drem <= '0;
    end
    if (cmd.div_step) begin
      rrem <= rge ? ClkW'(rtry - {1'b0, fdig}) : ClkW'(rtry);
      drem <= dge ? ClkW'(dtry - {1'b0, fxo}) : ClkW'(dtry);
      rdq  <= {rdq[62:0], rge};
      ddq  <= {ddq[62:0], dge};
    end
    if (cmd.mult) begin
      rlo <= fdig * {(re != '0), rdq[RateManW-1:0]};
      dlo <= fxo * {(de != '0), ddq[DevManW-1:0]};
    end
    if (cmd.diff) begin
      rdh <= {21'b0, rlo} + {38'b0, fdig} - rtgt;
      rdl <= rtgt - {21'b0, rlo};
      ddh <= {29'b0, dlo} + {38'b0, fxo} - dtgt;
      ddl <= dtgt - {29'b0, dlo};
    end
    if (cmd.finish) begin
      out_data <= {code | {4'b0, re}, de, dman, re, rman};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: test/mwe_checker.sv
module mwe_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [mwe_pkg::InW-1:0]  s_tdata,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [mwe_pkg::OutW-1:0] m_tdata,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [mwe_pkg::ClkW-1:0] cfg_data,
  output int                       fails,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mwe_pkg::*;

  typedef struct packed {
    logic [7:0]  mod2;
    logic [3:0]  dev_exp;
    logic [7:0]  dev_man;
    logic [3:0]  rate_exp;
    logic [15:0] rate_man;
  } words_t;

  logic [ClkW-1:0] crystal;
  logic [ClkW-1:0] threshold;
  words_t          word_queue[$];

  // 64-bit division that yields all ones for a zero clock.
  function automatic logic [63:0] clk_div(logic [63:0] n, logic [63:0] d);
    if (d == 64'd0) begin
      return '1;
    end
    return n / d;
  endfunction

  function automatic words_t encode_words(logic [31:0] rate, logic [31:0] dev,
                                          logic [7:0] code);
    logic [63:0] fdig, fxo, lim, tgt, base, lo, hi, q;
    logic [3:0]  re, de;
    words_t      w;
    fxo  = 64'(crystal);
    fdig = (crystal > threshold) ? (fxo >> 1) : fxo;
    re = 4'd12;
    for (int e = 0; e < 12; e++) begin
      lim = (e == 0) ? ((fdig * 64'd65535) >> 32) : ((fdig * 64'd131071) >> (33 - e));
      if (64'(rate) <= 64'(lim[31:0])) begin
        re = 4'(e);
        break;
      end
    end
    tgt  = (re == 0) ? (64'(rate) << 32) : (64'(rate) << (33 - re));
    base = (re == 0) ? 64'd0 : 64'd65536;
    q  = 64'(clk_div(tgt, fdig) & 64'hFFFF);
    lo = fdig * (q + base);
    hi = fdig * (q + 64'd1 + base);
    if ((hi - tgt) < (tgt - lo)) begin
      q = (q + 64'd1) & 64'hFFFF;
    end
    w.rate_man = q[15:0];
    w.rate_exp = re;
    de = 4'd12;
    for (int e = 0; e < 12; e++) begin
      lim = (e == 0) ? ((fxo * 64'd255) >> 22) : ((fxo * 64'd511) >> (23 - e));
      if (64'(dev) < 64'(lim[31:0])) begin
        de = 4'(e);
        break;
      end
    end
    tgt  = (de == 0) ? (64'(dev) << 22) : (64'(dev) << (23 - de));
    base = (de == 0) ? 64'd0 : 64'd256;
    q  = 64'(clk_div(tgt, fxo) & 64'hFF);
    lo = fxo * (q + base);
    hi = fxo * (q + 64'd1 + base);
    if ((hi - tgt) < (tgt - lo)) begin
      q = (q + 64'd1) & 64'hFF;
    end
    w.dev_man = q[7:0];
    w.dev_exp = de;
    w.mod2    = code | 8'(re);
    return w;
  endfunction

  always @(posedge clk) begin
    words_t want, got;
    if (rst) begin
      crystal   <= CrystalReset;
      threshold <= ThresholdReset;
      fails     <= 0;
      word_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgCrystal) begin
          crystal <= cfg_data;
        end else begin
          threshold <= cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        word_queue.push_back(encode_words(s_tdata[31:0], s_tdata[63:32], s_tdata[71:64]));
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (word_queue.size() == 0) begin
          $error("unexpected result item %h", m_tdata);
          fails <= fails + 1;
        end else begin
          want = word_queue.pop_front();
          if (got != want) begin
            fails <= fails + 1;
            if (got.rate_man != want.rate_man)
              $error("rate_mantissa exp %0d got %0d", want.rate_man, got.rate_man);
            if (got.rate_exp != want.rate_exp)
              $error("rate_exponent exp %0d got %0d", want.rate_exp, got.rate_exp);
            if (got.dev_man != want.dev_man)
              $error("dev_mantissa exp %0d got %0d", want.dev_man, got.dev_man);
            if (got.dev_exp != want.dev_exp)
              $error("dev_exponent exp %0d got %0d", want.dev_exp, got.dev_exp);
            if (got.mod2 != want.mod2)
              $error("mod2_byte exp %0h got %0h", want.mod2, got.mod2);
          end
        end
      end
    end
  end

  assign pending = word_queue.size();
endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mwe_pkg::*;

  localparam int WatchLimit = 3000;
  localparam int SettleWait = 100;
  localparam int PerPhase   = 155;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [InW-1:0]    s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OutW-1:0]   m_tdata;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CfgCrystal;
  logic [ClkW-1:0]   cfg_data = '0;
  int                fails;
  int                pending;

  // Registered copy of the input handshake, so the driver never races the edge.
  logic              in_taken = 1'b0;
  // In the closing part of the run both sides stream without idling.
  logic              calm = 1'b0;
  int                stall_left = 0;
  int                quiet = 0;

  always #5 clk = ~clk;

  modulation_word_encoder u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mwe_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready;
  end

  // The receiver stalls now and then in bursts of random length.
  always @(negedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // The watchdog counts cycles in which neither side accepts an item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Offers one item and holds it until the block takes it. Between items the
  // sender may go quiet for a burst of random length.
  task automatic send_item(logic [31:0] rate, logic [31:0] dev, logic [7:0] code);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {code, dev, rate};
    do @(negedge clk); while (!in_taken);
  endtask

  // Registers change only when the block holds no work.
  task automatic write_reg(logic idx, logic [ClkW-1:0] value);
    s_tvalid  <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Spans many exponents by shifting a random word right by a random amount.
  function automatic logic [31:0] spread_word();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom;
    end
    return $urandom >> $urandom_range(0, 31);
  endfunction

  initial begin
    logic [ClkW-1:0] crystals[8];
    logic [ClkW-1:0] thresholds[8];
    int              wait_cycles;
    crystals   = '{26'd50000000, 26'd24000000, 26'd52000000, 26'd0,
                   26'd1, 26'h3FFFFFF, 26'd40000000, 26'd26000000};
    thresholds = '{26'd30000000, 26'd0, 26'd52000000, 26'd30000000,
                   26'd0, 26'h3FFFFFF, 26'd30000000, 26'd26000000};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items under the reset settings: field extremes and the edges
    // of the first exponent for both the data rate and the deviation.
    send_item(32'd0, 32'd0, 8'h00);
    send_item(32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF);
    send_item(32'd381, 32'd3039, 8'h00);
    send_item(32'd382, 32'd3040, 8'hF0);
    send_item(32'd380, 32'd3038, 8'h0F);
    send_item(32'd1, 32'd1, 8'hAA);
    send_item(32'd762, 32'd6079, 8'h55);
    send_item(32'd763, 32'd6080, 8'h01);
    send_item(32'd250000, 32'd25000, 8'h10);
    send_item(32'd1000000, 32'd500000, 8'h20);
    send_item(32'd3124999, 32'd3110000, 8'h30);
    send_item(32'd3200000, 32'd3200000, 8'h40);
    send_item(32'd100000000, 32'd100000000, 8'h80);
    send_item(32'h80000000, 32'h80000000, 8'h00);
    send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 8'hFF);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_reg(CfgCrystal, crystals[ph]);
        write_reg(CfgThreshold, thresholds[ph]);
      end
      for (int k = 0; k < PerPhase; k++) begin
        if (ph == 7 && k >= PerPhase - 60) begin
          calm <= 1'b1;
        end
        send_item(spread_word(), spread_word(), 8'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20 * WatchLimit) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (SettleWait) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
